// ===== rtl/aslt_pkg.sv =====
// ----------------------------------------------------------------------------
// Staircase level tracker package
// Shared widths, payload types, register map and stop-rule patterns.
// ----------------------------------------------------------------------------
package aslt_pkg;

    localparam int LEVEL_WIDTH = 16;
    localparam int STEP_WIDTH  = 12;

    // Width that holds a level plus or minus twice the step without overflow.
    localparam int LVL_EXT_W = ((LEVEL_WIDTH > STEP_WIDTH + 1) ?
                                LEVEL_WIDTH : STEP_WIDTH + 1) + 2;

    localparam int HIST_W  = 9;
    localparam int MFLAG_W = 2;
    localparam int RUN_W   = 2;
    localparam int SEEN_W  = 4;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[4:2]).
    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_TWO_AFC     = 3'd1;
    localparam logic [2:0] REG_STEP_SIZE   = 3'd2;
    localparam logic [2:0] REG_START_LEVEL = 3'd3;
    localparam logic [2:0] REG_MIN_LEVEL   = 3'd4;
    localparam logic [2:0] REG_MAX_LEVEL   = 3'd5;

    // Operation codes.
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    // Register reset values.
    localparam logic [STEP_WIDTH-1:0]         STEP_RST  = STEP_WIDTH'(32);
    localparam logic signed [LEVEL_WIDTH-1:0] START_RST = LEVEL_WIDTH'(640);
    localparam logic signed [LEVEL_WIDTH-1:0] MIN_RST   = LEVEL_WIDTH'(-960);
    localparam logic signed [LEVEL_WIDTH-1:0] MAX_RST   = LEVEL_WIDTH'(1440);

    // Stop rules on the response history, newest response in bit 0.
    localparam logic [3:0]        RULE1_PAT = 4'b1001;
    localparam logic [SEEN_W-1:0] RULE1_LEN = SEEN_W'(4);
    localparam logic [8:0]        RULE2_PAT = 9'b101000101;
    localparam logic [SEEN_W-1:0] RULE2_LEN = SEEN_W'(9);
    localparam logic [1:0]        RULE3_PAT = 2'b00;
    localparam logic [SEEN_W-1:0] RULE3_LEN = SEEN_W'(2);
    localparam logic [SEEN_W-1:0] SEEN_MAX  = SEEN_W'(9);
    localparam logic [RUN_W-1:0]  TWO_AFC_RUN = RUN_W'(3);
    localparam logic [RUN_W-1:0]  ONE_RUN     = RUN_W'(1);

    typedef struct packed {
        logic                          operation;
        logic signed [LEVEL_WIDTH-1:0] presented_level;
        logic                          response;
        logic                          at_max;
    } t_in_item;

    typedef struct packed {
        logic signed [LEVEL_WIDTH-1:0] next_level;
        logic                          stop;
    } t_out_item;

endpackage

// ===== rtl/adaptive_staircase_level_tracker.sv =====
// A result passes through the input register and then the result register.
// One beat per cycle while the result side is not stalled; the track state is updated as each beat moves on.
// The input register and the result register move together, so a stalled
// result holds both stages and ready falls only when both are full.
// Reset (synchronous, active low) clears the track state and the valid
// flags and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// Adaptive staircase level tracker
// Up-down and two-step-down staircase with clamp and stop-rule detection.
// ----------------------------------------------------------------------------
module adaptive_staircase_level_tracker
    import aslt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration registers
    logic                          r_mode;
    logic                          r_two_afc;
    logic [STEP_WIDTH-1:0]         r_step_size;
    logic signed [LEVEL_WIDTH-1:0] r_start_level;
    logic signed [LEVEL_WIDTH-1:0] r_min_level;
    logic signed [LEVEL_WIDTH-1:0] r_max_level;

    // Track state
    logic [RUN_W-1:0]   r_correct_run,  n_correct_run;
    logic [HIST_W-1:0]  r_resp_hist,    n_resp_hist;
    logic [MFLAG_W-1:0] r_mflag_hist,   n_mflag_hist;
    logic [SEEN_W-1:0]  r_trials_seen,  n_trials_seen;

    // Pipeline
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out, n_out;

    logic                      out_free;
    logic                      advance;
    logic                      cfg_wr;
    logic [2:0]                reg_idx;
    logic signed [LVL_EXT_W-1:0] lev;
    logic signed [LVL_EXT_W-1:0] step_ext;
    logic signed [LVL_EXT_W-1:0] lo_ext;
    logic signed [LVL_EXT_W-1:0] hi_ext;
    logic signed [LVL_EXT_W-1:0] clamp_in;
    logic [RUN_W-1:0]            run_inc;
    logic [RUN_W-1:0]            run_need;
    logic                        stop;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[PADDR_W-1:2];
    assign cfg_wr   = psel & penable & pwrite & pready;

    assign out_free   = !r_out_vld || i_out_ready;
    assign advance    = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || out_free;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_MODE:        prdata = PDATA_W'(r_mode);
            REG_TWO_AFC:     prdata = PDATA_W'(r_two_afc);
            REG_STEP_SIZE:   prdata = PDATA_W'(r_step_size);
            REG_START_LEVEL: prdata = PDATA_W'($unsigned(r_start_level));
            REG_MIN_LEVEL:   prdata = PDATA_W'($unsigned(r_min_level));
            REG_MAX_LEVEL:   prdata = PDATA_W'($unsigned(r_max_level));
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_two_afc     <= 1'b0;
            r_step_size   <= STEP_RST;
            r_start_level <= START_RST;
            r_min_level   <= MIN_RST;
            r_max_level   <= MAX_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MODE:        r_mode        <= pwdata[0];
                REG_TWO_AFC:     r_two_afc     <= pwdata[0];
                REG_STEP_SIZE:   r_step_size   <= pwdata[STEP_WIDTH-1:0];
                REG_START_LEVEL: r_start_level <= $signed(pwdata[LEVEL_WIDTH-1:0]);
                REG_MIN_LEVEL:   r_min_level   <= $signed(pwdata[LEVEL_WIDTH-1:0]);
                REG_MAX_LEVEL:   r_max_level   <= $signed(pwdata[LEVEL_WIDTH-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Level update, run counter and stop rules for the item in the input register.
    always_comb begin
        step_ext = $signed({{(LVL_EXT_W-STEP_WIDTH){1'b0}}, r_step_size});
        lo_ext   = LVL_EXT_W'(r_min_level);
        hi_ext   = LVL_EXT_W'(r_max_level);
        lev      = LVL_EXT_W'(r_in.presented_level);
        run_inc  = r_correct_run + ONE_RUN;
        run_need = r_two_afc ? TWO_AFC_RUN : ONE_RUN;
        stop     = 1'b0;

        n_correct_run = r_correct_run;
        n_resp_hist   = {r_resp_hist[HIST_W-2:0], r_in.response};
        n_mflag_hist  = {r_mflag_hist[MFLAG_W-2:0], r_in.at_max};
        n_trials_seen = (r_trials_seen < SEEN_MAX) ? r_trials_seen + SEEN_W'(1)
                                                   : r_trials_seen;
        clamp_in = lev;

        if (r_in.operation == OP_BEGIN) begin
            n_correct_run = '0;
            n_resp_hist   = '0;
            n_mflag_hist  = '0;
            n_trials_seen = '0;
            clamp_in      = LVL_EXT_W'(r_start_level);
        end else if (!r_mode) begin
            if (!r_in.response) begin
                clamp_in      = lev + step_ext;
                n_correct_run = '0;
            end else if (run_inc >= run_need) begin
                clamp_in      = lev - step_ext;
                n_correct_run = '0;
            end else begin
                n_correct_run = run_inc;
            end
        end else begin
            clamp_in = r_in.response ? lev - (step_ext <<< 1) : lev + step_ext;
            if (n_trials_seen >= RULE1_LEN && n_resp_hist[3:0] == RULE1_PAT) begin
                stop = 1'b1;
            end else if (n_trials_seen >= RULE2_LEN &&
                         n_resp_hist[8:0] == RULE2_PAT) begin
                stop = 1'b1;
            end else if (n_trials_seen >= RULE3_LEN && n_resp_hist[1:0] == RULE3_PAT &&
                         n_mflag_hist == '1) begin
                stop = 1'b1;
            end
        end

        // Minimum takes priority when the limits are crossed.
        if (clamp_in < lo_ext) begin
            n_out.next_level = r_min_level;
        end else if (clamp_in > hi_ext) begin
            n_out.next_level = r_max_level;
        end else begin
            n_out.next_level = clamp_in[LEVEL_WIDTH-1:0];
        end
        n_out.stop = stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_correct_run <= '0;
            r_resp_hist   <= '0;
            r_mflag_hist  <= '0;
            r_trials_seen <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (advance) begin
                r_correct_run <= n_correct_run;
                r_resp_hist   <= n_resp_hist;
                r_mflag_hist  <= n_mflag_hist;
                r_trials_seen <= n_trials_seen;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== tb/tb_adaptive_staircase_level_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Staircase level tracker testbench
// Drives begin and trial beats through the valid/ready input with random
// gaps and result back-pressure. It reprograms the staircase over the APB
// port between phases, and checks every result against a scoreboard that
// tracks the level, the correct-response run and the stop-rule histories.
// ----------------------------------------------------------------------------
module tb_adaptive_staircase_level_tracker;
    import aslt_pkg::*;

    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   RANDOM_ITEMS = 1125;
    localparam int   MAX_GAP      = 11;
    localparam int   LONG_HOLD    = 150;
    localparam logic MODE_UPDOWN  = 1'b0;
    localparam logic MODE_ANSI    = 1'b1;

    class staircase_scoreboard;
        logic                          cfg_mode;
        logic                          cfg_two_afc;
        logic [STEP_WIDTH-1:0]         cfg_step;
        logic signed [LEVEL_WIDTH-1:0] cfg_start;
        logic signed [LEVEL_WIDTH-1:0] cfg_min;
        logic signed [LEVEL_WIDTH-1:0] cfg_max;
        logic [RUN_W-1:0]              run_len;
        logic [HIST_W-1:0]             resp_hist;
        logic [MFLAG_W-1:0]            atmax_hist;
        logic [SEEN_W-1:0]             trials_seen;
        logic signed [LEVEL_WIDTH-1:0] track_level;
        t_out_item                     pending_levels[$];
        int                            fail_count;
        int                            checked;
        int                            stops_seen;

        function new();
            cfg_mode    = MODE_UPDOWN;
            cfg_two_afc = 1'b0;
            cfg_step    = STEP_RST;
            cfg_start   = START_RST;
            cfg_min     = MIN_RST;
            cfg_max     = MAX_RST;
            run_len     = '0;
            resp_hist   = '0;
            atmax_hist  = '0;
            trials_seen = '0;
            track_level = START_RST;
            fail_count  = 0;
            checked     = 0;
            stops_seen  = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [PDATA_W-1:0] data);
            case (idx)
                REG_MODE:        cfg_mode    = data[0];
                REG_TWO_AFC:     cfg_two_afc = data[0];
                REG_STEP_SIZE:   cfg_step    = data[STEP_WIDTH-1:0];
                REG_START_LEVEL: cfg_start   = data[LEVEL_WIDTH-1:0];
                REG_MIN_LEVEL:   cfg_min     = data[LEVEL_WIDTH-1:0];
                REG_MAX_LEVEL:   cfg_max     = data[LEVEL_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        // Below the minimum wins over above the maximum, which decides the
        // result when the limits are inverted.
        function logic signed [LEVEL_WIDTH-1:0] clamp_level(int lvl);
            if (lvl < int'(cfg_min))
                return cfg_min;
            if (lvl > int'(cfg_max))
                return cfg_max;
            return LEVEL_WIDTH'(lvl);
        endfunction

        function void predict_next_level(t_in_item beat);
            int               lvl;
            t_out_item        res;
            logic [RUN_W-1:0] need;
            lvl = int'(beat.presented_level);
            res.stop = 1'b0;
            if (beat.operation == OP_BEGIN) begin
                run_len     = '0;
                resp_hist   = '0;
                atmax_hist  = '0;
                trials_seen = '0;
                res.next_level = clamp_level(int'(cfg_start));
            end else begin
                resp_hist  = {resp_hist[HIST_W-2:0], beat.response};
                atmax_hist = {atmax_hist[0], beat.at_max};
                if (trials_seen < SEEN_MAX)
                    trials_seen = trials_seen + 1'b1;
                if (cfg_mode == MODE_UPDOWN) begin
                    need = cfg_two_afc ? TWO_AFC_RUN : ONE_RUN;
                    if (!beat.response) begin
                        lvl     = lvl + int'(cfg_step);
                        run_len = '0;
                    end else begin
                        run_len = run_len + 1'b1;
                        if (run_len >= need) begin
                            lvl     = lvl - int'(cfg_step);
                            run_len = '0;
                        end
                    end
                end else begin
                    if (!beat.response)
                        lvl = lvl + int'(cfg_step);
                    else
                        lvl = lvl - 2 * int'(cfg_step);
                    // A pattern only counts once the track is at least as
                    // long as the pattern.
                    res.stop = (resp_hist[3:0] == RULE1_PAT && trials_seen >= RULE1_LEN) ||
                               (resp_hist == RULE2_PAT && trials_seen >= RULE2_LEN) ||
                               (resp_hist[1:0] == RULE3_PAT && trials_seen >= RULE3_LEN &&
                                atmax_hist == 2'b11);
                end
                res.next_level = clamp_level(lvl);
            end
            track_level = res.next_level;
            pending_levels.push_back(res);
        endfunction

        function void check_next_level(t_out_item got);
            t_out_item want;
            if (pending_levels.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected result beat: next_level %0d stop %0b",
                             got.next_level, got.stop);
                return;
            end
            want = pending_levels.pop_front();
            checked++;
            if (got.next_level !== want.next_level || got.stop !== want.stop) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Mismatch on result %0d: next_level exp %0d got %0d, stop exp %0b got %0b",
                             checked, want.next_level, got.next_level, want.stop, got.stop);
            end
            if (got.stop === 1'b1)
                stops_seen++;
        endfunction

        function int pending();
            return pending_levels.size();
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in        = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    staircase_scoreboard sb;
    int cycle_count   = 0;
    int tx_max_gap    = 0;
    int rx_max_gap    = 0;
    int rx_hold_req   = 0;
    int beats_sent    = 0;
    int config_writes = 0;
    int phase_count   = 0;

    adaptive_staircase_level_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic op, logic signed [LEVEL_WIDTH-1:0] lvl,
                             logic resp, logic am);
        int       gap;
        t_in_item beat;
        beat.operation       = op;
        beat.presented_level = lvl;
        beat.response        = resp;
        beat.at_max          = am;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.predict_next_level(beat);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // Leaves the bus in its access state; configure_track releases it.
    task automatic write_register(logic [2:0] idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_register(idx, PDATA_W'(value));
        config_writes++;
        @(negedge i_clk);
    endtask

    task automatic configure_track(logic m, logic afc, int st, int start_lvl,
                                   int lo, int hi);
        write_register(REG_MODE, int'(m));
        write_register(REG_TWO_AFC, int'(afc));
        write_register(REG_STEP_SIZE, st);
        write_register(REG_START_LEVEL, start_lvl);
        write_register(REG_MIN_LEVEL, lo);
        write_register(REG_MAX_LEVEL, hi);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        phase_count++;
    endtask

    task automatic randomize_config();
        int st, lo, hi, sl;
        case ($urandom_range(0, 5))
            0:       st = 0;
            1:       st = 4095;
            default: st = $urandom_range(1, 96);
        endcase
        case ($urandom_range(0, 7))
            0: begin
                lo = -32768;
                hi = 32767;
            end
            1: begin
                lo = $urandom_range(0, 600);
                hi = lo - int'($urandom_range(0, 400));
            end
            default: begin
                lo = -int'($urandom_range(0, 1600));
                hi = lo + int'($urandom_range(64, 2400));
            end
        endcase
        case ($urandom_range(0, 5))
            0:       sl = -32768;
            1:       sl = 32767;
            default: sl = int'($urandom_range(0, 4000)) - 2000;
        endcase
        configure_track(1'($urandom), 1'($urandom), st, sl, lo, hi);
    endtask

    // Mostly a proper track that presents the level last returned; the rest
    // is new tracks and beats with arbitrary fields.
    task automatic send_random_item(int pct_correct);
        int                            pick;
        logic signed [LEVEL_WIDTH-1:0] lvl;
        pick = $urandom_range(0, 99);
        lvl  = sb.track_level;
        if (pick < 4)
            send_item(OP_BEGIN, LEVEL_WIDTH'($urandom), 1'($urandom), 1'($urandom));
        else if (pick < 88)
            send_item(OP_TRIAL, lvl, $urandom_range(0, 99) < pct_correct,
                      (lvl == sb.cfg_max) ^ ($urandom_range(0, 19) == 0));
        else
            send_item(1'($urandom), LEVEL_WIDTH'($urandom), 1'($urandom), 1'($urandom));
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (rx_hold_req > 0) begin
                stall = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                stall = $urandom_range(0, rx_max_gap);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_next_level(o_out);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [HIST_W-1:0] long_rule;
        int                random_sent;
        int                n_items;
        int                pct;
        sb = new();
        long_rule   = RULE2_PAT;
        random_sent = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: a trial on the reset state, then the level
        // extremes with both clamps.
        tx_max_gap = 2;
        rx_max_gap = 2;
        send_item(OP_TRIAL, 16'sd100, 1'b0, 1'b0);
        send_item(OP_BEGIN, 16'sh7FFF, 1'b1, 1'b1);
        send_item(OP_TRIAL, 16'sh7FFF, 1'b0, 1'b1);
        send_item(OP_TRIAL, 16'sh8000, 1'b1, 1'b0);
        wait_for_results();

        // Inverted limits with the largest step and a three-correct run.
        configure_track(MODE_UPDOWN, 1'b1, 4095, -32768, 32767, -32768);
        send_item(OP_BEGIN, 16'sd0, 1'b0, 1'b0);
        repeat (3) send_item(OP_TRIAL, 16'sh7FFF, 1'b1, 1'b1);
        wait_for_results();

        // Two-step-down mode: the 1001 rule, then two misses at the maximum.
        configure_track(MODE_ANSI, 1'b0, 16, 0, -32768, 32767);
        send_item(OP_BEGIN, 16'sd0, 1'b0, 1'b0);
        send_item(OP_TRIAL, sb.track_level, 1'b1, 1'b0);
        send_item(OP_TRIAL, sb.track_level, 1'b0, 1'b0);
        send_item(OP_TRIAL, sb.track_level, 1'b0, 1'b0);
        send_item(OP_TRIAL, sb.track_level, 1'b1, 1'b0);
        send_item(OP_TRIAL, sb.track_level, 1'b0, 1'b1);
        send_item(OP_TRIAL, sb.track_level, 1'b0, 1'b1);
        wait_for_results();

        // The nine-response rule, oldest response first.
        send_item(OP_BEGIN, 16'sd0, 1'b0, 1'b0);
        for (int i = HIST_W - 1; i >= 0; i--)
            send_item(OP_TRIAL, sb.track_level, long_rule[i], 1'b0);
        wait_for_results();

        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: begin
                    tx_max_gap = 0;
                    rx_max_gap = 0;
                end
                1: begin
                    tx_max_gap = MAX_GAP;
                    rx_max_gap = 0;
                end
                2: begin
                    tx_max_gap = 0;
                    rx_max_gap = MAX_GAP;
                end
                default: begin
                    tx_max_gap = MAX_GAP;
                    rx_max_gap = MAX_GAP;
                end
            endcase
            // Hold the result side off while beats keep coming, so the
            // pipeline fills and the input stalls.
            if (phase_count == 5 || phase_count == 12) begin
                tx_max_gap  = 0;
                rx_hold_req = LONG_HOLD;
            end
            randomize_config();
            if ($urandom_range(0, 4) != 0) begin
                send_item(OP_BEGIN, LEVEL_WIDTH'($urandom), 1'($urandom), 1'($urandom));
                random_sent++;
            end
            n_items = $urandom_range(30, 110);
            pct     = $urandom_range(25, 85);
            repeat (n_items) begin
                if (random_sent < RANDOM_ITEMS) begin
                    send_random_item(pct);
                    random_sent++;
                end
            end
            wait_for_results();
        end

        repeat (8) @(posedge i_clk);
        $display("Run covered %0d beats over %0d register settings (%0d writes).",
                 beats_sent, phase_count, config_writes);
        $display("%0d results checked, %0d with stop set, %0d mismatches.",
                 sb.checked, sb.stops_seen, sb.fail_count);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
